// ===== rtl/core/first_fit_block_allocator_core_macros.svh =====
// Assertion macros shared by the allocator core modules.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator core.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned SIZE_W = 12;  // sizes and offsets on the ports
  localparam int unsigned POS_W  = 14;  // arena position plus header plus capacity

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic {
    ST_DONE   = 1'b0,
    ST_NO_FIT = 1'b1
  } status_e;

  // One block header as kept in the block store.
  typedef struct packed {
    logic  free;
    size_t cap;
  } blk_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_GOT_H = 6'b000010,
    S_EVAL  = 6'b000100,
    S_GOT_N = 6'b001000,
    S_SPLIT = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  typedef struct packed {
    logic start;      // latch transaction, point at offset 0
    logic got_h;      // capture current block header
    logic advance;    // step to next block and read it
    logic rd_next;    // read next block header
    logic merge;      // fold next block into current if both free
    logic mark_free;  // set current block free
    logic take;       // mark current block used, record grant
    logic split_wr;   // write header of split remainder
    logic set_fail;   // no block fits
    logic respond;    // load output register
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic tgt_bad;
    logic n_exists;
    logic can_merge;
    logic fits;
    logic split_ok;
    logic h_lt_tgt;
    logic h_eq_tgt;
    logic out_full;
  } dp_stat_t;

endpackage

// ===== rtl/core/ffba_datapath.sv =====
// ----------------------------------------------------------------------------
// ffba_datapath
// Block store, walk registers, arithmetic and output register.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_core_macros.svh"

module ffba_datapath #(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 17,
  parameter int unsigned MIN_CAPACITY = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            op_i,
  input  logic [ffba_pkg::SIZE_W-1:0]     req_size_i,
  input  logic [ffba_pkg::SIZE_W-1:0]     free_offset_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            status_o,
  output logic [ffba_pkg::SIZE_W-1:0]     grant_offset_o,
  input  ffba_pkg::dp_cmd_t               cmd_i,
  output ffba_pkg::dp_stat_t              stat_o
);

  localparam int unsigned AW = $clog2(ARENA_BYTES);
  localparam int unsigned PW = ffba_pkg::POS_W;
  localparam int unsigned SW = ffba_pkg::SIZE_W;
  localparam ffba_pkg::pos_t HdrPos   = PW'(HEADER_BYTES);
  localparam ffba_pkg::pos_t MinPos   = PW'(MIN_CAPACITY);
  localparam ffba_pkg::pos_t ArenaPos = PW'(ARENA_BYTES);

  // Transaction registers
  ffba_pkg::op_e     op_q;
  ffba_pkg::size_t   q_q;
  ffba_pkg::size_t   tgt_q;
  logic              tgt_bad_q;

  // Walk registers
  ffba_pkg::pos_t    h_q;
  ffba_pkg::size_t   cap_h_q;
  logic              free_h_q;
  logic              merge_stop_q;

  // Block store; entry zero lives in flops so that it has a reset value
  ffba_pkg::blk_t    mem_q [ARENA_BYTES];
  ffba_pkg::blk_t    blk0_q;
  ffba_pkg::blk_t    rd_data_q;
  logic              rd_zero_q;

  // Result and output registers
  logic              res_fail_q;
  ffba_pkg::size_t   res_grant_q;
  logic              out_valid_q;
  ffba_pkg::status_e out_status_q;
  ffba_pkg::size_t   out_grant_q;

  ffba_pkg::blk_t    rd_blk;
  ffba_pkg::pos_t    n_pos;
  ffba_pkg::pos_t    r_pos;
  ffba_pkg::size_t   merged_cap;
  ffba_pkg::size_t   rem_cap;
  logic              split_ok;
  logic              merge_hit;
  logic [SW:0]       tgt_full;
  ffba_pkg::size_t   q_in;

  logic              rd_en;
  ffba_pkg::pos_t    rd_pos;
  logic              wr_en;
  ffba_pkg::pos_t    wr_pos;
  ffba_pkg::blk_t    wr_word;

  assign rd_blk     = rd_zero_q ? blk0_q : rd_data_q;
  assign n_pos      = h_q + HdrPos + PW'(cap_h_q);
  assign r_pos      = h_q + HdrPos + PW'(q_q);
  assign merged_cap = SW'(PW'(cap_h_q) + HdrPos + PW'(rd_blk.cap));
  assign rem_cap    = SW'(PW'(cap_h_q) - PW'(q_q) - HdrPos);
  assign split_ok   = (PW'(q_q) + HdrPos + MinPos) <= PW'(cap_h_q);
  assign merge_hit  = rd_blk.free & free_h_q;

  assign tgt_full = {1'b0, free_offset_i} - (SW+1)'(HEADER_BYTES);
  assign q_in     = (req_size_i < SW'(MIN_CAPACITY)) ? SW'(MIN_CAPACITY) : req_size_i;

  // Read port
  assign rd_en  = cmd_i.start | cmd_i.advance | cmd_i.rd_next;
  assign rd_pos = cmd_i.start ? '0 : n_pos;

  // Write port
  always_comb begin
    wr_en   = 1'b0;
    wr_pos  = h_q;
    wr_word = '{free: 1'b1, cap: cap_h_q};
    if (cmd_i.mark_free) begin
      wr_en = 1'b1;
    end else if (cmd_i.merge && merge_hit) begin
      wr_en        = 1'b1;
      wr_word.cap  = merged_cap;
    end else if (cmd_i.take) begin
      wr_en        = 1'b1;
      wr_word.free = 1'b0;
      wr_word.cap  = split_ok ? q_q : cap_h_q;
    end else if (cmd_i.split_wr) begin
      wr_en   = 1'b1;
      wr_pos  = r_pos;
      wr_word = '{free: 1'b1, cap: rem_cap};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_pos != '0)) begin
      mem_q[wr_pos[AW-1:0]] <= wr_word;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_pos[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk0_q    <= '{free: 1'b1, cap: SW'(ARENA_BYTES - HEADER_BYTES)};
      rd_zero_q <= 1'b0;
    end else begin
      if (wr_en && (wr_pos == '0)) begin
        blk0_q <= wr_word;
      end
      if (rd_en) begin
        rd_zero_q <= (rd_pos == '0);
      end
    end
  end

  // Transaction and walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= ffba_pkg::OP_ALLOC;
      q_q          <= '0;
      tgt_q        <= '0;
      tgt_bad_q    <= 1'b0;
      h_q          <= '0;
      cap_h_q      <= '0;
      free_h_q     <= 1'b0;
      merge_stop_q <= 1'b0;
      res_fail_q   <= 1'b0;
      res_grant_q  <= '0;
    end else begin
      if (cmd_i.start) begin
        op_q        <= ffba_pkg::op_e'(op_i);
        q_q         <= q_in;
        tgt_q       <= tgt_full[SW-1:0];
        tgt_bad_q   <= tgt_full[SW];
        h_q         <= '0;
        res_fail_q  <= 1'b0;
        res_grant_q <= '0;
      end
      if (cmd_i.got_h) begin
        cap_h_q      <= rd_blk.cap;
        free_h_q     <= rd_blk.free;
        merge_stop_q <= 1'b0;
      end
      if (cmd_i.advance) begin
        h_q <= n_pos;
      end
      if (cmd_i.merge) begin
        if (merge_hit) begin
          cap_h_q <= merged_cap;
        end else begin
          merge_stop_q <= 1'b1;
        end
      end
      if (cmd_i.mark_free) begin
        free_h_q <= 1'b1;
      end
      if (cmd_i.take) begin
        res_grant_q <= SW'(h_q + HdrPos);
      end
      if (cmd_i.set_fail) begin
        res_fail_q <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= ffba_pkg::ST_DONE;
      out_grant_q  <= '0;
    end else if (cmd_i.respond) begin
      out_valid_q  <= 1'b1;
      out_status_q <= res_fail_q ? ffba_pkg::ST_NO_FIT : ffba_pkg::ST_DONE;
      out_grant_q  <= res_grant_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign grant_offset_o = out_grant_q;

  always_comb begin
    stat_o.op        = op_q;
    stat_o.tgt_bad   = tgt_bad_q;
    stat_o.n_exists  = n_pos < ArenaPos;
    stat_o.can_merge = free_h_q & ~merge_stop_q & (n_pos < ArenaPos);
    stat_o.fits      = free_h_q & (cap_h_q >= q_q);
    stat_o.split_ok  = split_ok;
    stat_o.h_lt_tgt  = h_q < PW'(tgt_q);
    stat_o.h_eq_tgt  = h_q == PW'(tgt_q);
    stat_o.out_full  = out_valid_q & ~out_ready_i;
  end

  `FFBA_ASSERT_IMP(a_wr_in_arena, clk_i, rst_ni, wr_en, wr_pos < ArenaPos, "write outside arena")
  `FFBA_ASSERT_IMP(a_no_rw_clash, clk_i, rst_ni, rd_en && wr_en, rd_pos != wr_pos, "read/write clash")
  `FFBA_ASSERT_IMP(a_split_min, clk_i, rst_ni, cmd_i.split_wr, PW'(rem_cap) >= MinPos, "split too small")

endmodule

// ===== rtl/core/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for the allocate walk and the free lookup.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_core_macros.svh"

module ffba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ffba_pkg::dp_stat_t stat_i,
  output ffba_pkg::dp_cmd_t  cmd_o
);

  ffba_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ffba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ffba_pkg::S_GOT_H;
        end
      end
      ffba_pkg::S_GOT_H: begin
        cmd_o.got_h = 1'b1;
        state_d     = ffba_pkg::S_EVAL;
      end
      ffba_pkg::S_EVAL: begin
        if (stat_i.op == ffba_pkg::OP_ALLOC) begin
          if (stat_i.can_merge) begin
            cmd_o.rd_next = 1'b1;
            state_d       = ffba_pkg::S_GOT_N;
          end else if (stat_i.fits) begin
            cmd_o.take = 1'b1;
            state_d    = stat_i.split_ok ? ffba_pkg::S_SPLIT : ffba_pkg::S_RESP;
          end else if (stat_i.n_exists) begin
            cmd_o.advance = 1'b1;
            state_d       = ffba_pkg::S_GOT_H;
          end else begin
            cmd_o.set_fail = 1'b1;
            state_d        = ffba_pkg::S_RESP;
          end
        end else begin
          state_d = ffba_pkg::S_RESP;
          if (stat_i.tgt_bad) begin
            // offset below one header: nothing to free
          end else if (stat_i.h_eq_tgt) begin
            cmd_o.mark_free = 1'b1;
            if (stat_i.n_exists) begin
              cmd_o.rd_next = 1'b1;
              state_d       = ffba_pkg::S_GOT_N;
            end
          end else if (stat_i.h_lt_tgt && stat_i.n_exists) begin
            cmd_o.advance = 1'b1;
            state_d       = ffba_pkg::S_GOT_H;
          end
        end
      end
      ffba_pkg::S_GOT_N: begin
        cmd_o.merge = 1'b1;
        state_d = (stat_i.op == ffba_pkg::OP_ALLOC) ? ffba_pkg::S_EVAL : ffba_pkg::S_RESP;
      end
      ffba_pkg::S_SPLIT: begin
        cmd_o.split_wr = 1'b1;
        state_d        = ffba_pkg::S_RESP;
      end
      ffba_pkg::S_RESP: begin
        if (!stat_i.out_full) begin
          cmd_o.respond = 1'b1;
          state_d       = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `FFBA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "second transaction taken")
  `FFBA_ASSERT_IMP(a_resp_only_free, clk_i, rst_ni, cmd_o.respond, !stat_i.out_full, "output overwritten")
  `FFBA_ASSERT_IMP(a_split_after_fit, clk_i, rst_ni, cmd_o.take, stat_i.fits && stat_i.op == ffba_pkg::OP_ALLOC, "take without fit")

endmodule

// ===== rtl/core/first_fit_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over a fixed arena with split on allocate and
// coalescing of free neighbors.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake               Payload
//  in       in   in_valid_i/in_ready_o   op_i, req_size_i, free_offset_i
//  out      out  out_valid_o/out_ready_i status_o, grant_offset_o
//
//  One transaction is worked at a time; the block store has one read port
//  and one write port, and each block header read is registered.
//  Allocate: a header read and evaluation per block visited, a read and merge
//  per merged or checked free successor, a split write when one is due. Free:
//  a header read and evaluation per block up to the target, then a merge check.
//  No clearing pass after reset; the first block's header resets in flops.
//  A waiting result does not block a new input; only its write-back stalls.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core #(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 17,
  parameter int unsigned MIN_CAPACITY = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [ffba_pkg::SIZE_W-1:0] req_size_i,
  input  logic [ffba_pkg::SIZE_W-1:0] free_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic [ffba_pkg::SIZE_W-1:0] grant_offset_o
);

  ffba_pkg::dp_cmd_t  cmd;
  ffba_pkg::dp_stat_t stat;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffba_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MIN_CAPACITY (MIN_CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op_i),
    .req_size_i     (req_size_i),
    .free_offset_i  (free_offset_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .grant_offset_o (grant_offset_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule
